### hw/rtl/sn83_pkg.sv
`timescale 1ns / 1ps
package sn83_pkg;

  localparam int NAME_LEN     = 11;
  localparam int BASE_LEN_DEF = 8;
  localparam int EXT_START    = 8;
  localparam int Q_DEPTH      = 2;
  localparam int IDX_W        = $clog2(NAME_LEN);

  localparam logic [7:0] PAD_CHAR  = 8'h20;
  localparam logic [7:0] NUL_CHAR  = 8'h00;
  localparam logic [7:0] SEP_CHAR  = 8'h2F;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] PRINT_LO  = 8'h21;
  localparam logic [7:0] PRINT_HI  = 8'h7E;
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  typedef logic [NAME_LEN-1:0][7:0] name_t;

  // one finished name waiting for the output side
  typedef struct packed {
    name_t bytes;
    logic  ok;
  } name_entry_t;

  // handshake between two stages
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  function automatic logic is_forbidden(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    unique case (c)
      8'h7C, 8'h3C, 8'h3E, 8'h5E, 8'h2B, 8'h3D, 8'h3F, 8'h2F,
      8'h5B, 8'h5D, 8'h3B, 8'h2C, 8'h2A, 8'h22, 8'h5C: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

### hw/rtl/short_name_8_3_parser.sv
`timescale 1ns / 1ps
// 8.3 short name builder
// input channel: one path character per word on in_char_in (valid/ready).
//   ordinary characters produce nothing; 0x00 or '/' ends the name
// output channel: for each ended name, 11 words of name_byte, byte_index
//   0..10, name_ok (same on all 11) and last on byte 10, space padded
// throughput: the input side takes one character per cycle while the queue has
//   room; the output side sends one byte per cycle while out_ready is high
// the first byte of a name appears once its terminator's entry has been
//   written into the queue and then popped into the output shift register
// a two-entry name queue sits between the builder and the serializer, so
//   the next name keeps streaming in while the receiver stalls; in_ready
//   drops only once both queue entries are taken
// reset: synchronous active-low rst_n clears the name under construction
//   to spaces, empties the queue and idles the output
module short_name_8_3_parser #(
  parameter int BASE_LEN = sn83_pkg::BASE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_name_byte,
  output logic [3:0] out_byte_index,
  output logic       out_name_ok,
  output logic       out_last
);
  import sn83_pkg::*;

  hs_t         push_hs;
  name_entry_t push_entry;
  name_entry_t q_entry;
  logic        q_ready;
  logic        q_valid;
  logic        pop;

  // front: classify characters and build the 11-byte name
  sn83_front #(
    .BASE_LEN (BASE_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char_in (in_char_in),
    .push_hs    (push_hs),
    .push_entry (push_entry),
    .q_ready    (q_ready)
  );

  // finished names waiting for the serializer
  sn83_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_hs    (push_hs),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop)
  );

  // back: send the name out one byte per word
  sn83_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_name_byte  (out_name_byte),
    .out_byte_index (out_byte_index),
    .out_name_ok    (out_name_ok),
    .out_last       (out_last)
  );

  // last flag only on the final byte position
  a_last_idx : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_byte_index == 4'(NAME_LEN - 1))
    else $error("last flag on wrong byte index");

  // within a name the index steps by one per word
  a_idx_step : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_byte_index == $past(out_byte_index) + 4'd1))
    else $error("byte index did not advance");

  // name_ok holds across all bytes of one name
  a_ok_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_name_ok == $past(out_name_ok))
    else $error("name_ok changed inside a name");

  // a name starts at byte 0 whenever out_valid rises
  a_start_zero : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_byte_index == 4'd0)
    else $error("name did not start at byte 0");

endmodule

### hw/rtl/sn83_front.sv
`timescale 1ns / 1ps
module sn83_front #(
  parameter int BASE_LEN = sn83_pkg::BASE_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_char_in,
  output sn83_pkg::hs_t         push_hs,
  output sn83_pkg::name_entry_t push_entry,
  input  logic                  q_ready
);
  import sn83_pkg::*;

  localparam int POS_W = IDX_W + 1;
  localparam logic [POS_W-1:0] BASE_LIMIT = POS_W'(BASE_LEN - 1);
  localparam logic [POS_W-1:0] EXT_LIMIT  = POS_W'(NAME_LEN - 1);

  name_t            store_r, store_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             dot_r, dot_nxt;
  logic             fail_r, fail_nxt;

  logic             acc;
  logic             is_term;
  logic             bad_char;
  logic [POS_W-1:0] limit;
  logic [7:0]       up_char;

  assign in_ready = q_ready;
  assign acc      = in_valid && in_ready;
  assign is_term  = (in_char_in == NUL_CHAR) || (in_char_in == SEP_CHAR);
  assign bad_char = is_forbidden(in_char_in) || (in_char_in < PRINT_LO) ||
                    (in_char_in > PRINT_HI);
  assign limit    = dot_r ? EXT_LIMIT : BASE_LIMIT;
  assign up_char  = ((in_char_in >= LOWER_A) && (in_char_in <= LOWER_Z)) ?
                    (in_char_in - CASE_DIFF) : in_char_in;

  assign push_hs.valid    = in_valid && is_term;
  assign push_hs.ready    = q_ready;
  assign push_entry.bytes = store_r;
  assign push_entry.ok    = !fail_r && (store_r[0] != PAD_CHAR);

  always_comb begin
    store_nxt = store_r;
    pos_nxt   = pos_r;
    dot_nxt   = dot_r;
    fail_nxt  = fail_r;
    if (acc) begin
      if (is_term) begin
        store_nxt = {NAME_LEN{PAD_CHAR}};
        pos_nxt   = '0;
        dot_nxt   = 1'b0;
        fail_nxt  = 1'b0;
      end else if (!fail_r) begin
        if (in_char_in == DOT_CHAR) begin
          if (dot_r) begin
            fail_nxt = 1'b1;
          end else begin
            dot_nxt = 1'b1;
            pos_nxt = POS_W'(EXT_START);
          end
        end else if (bad_char || (pos_r > limit)) begin
          fail_nxt = 1'b1;
        end else begin
          for (int k = 0; k < NAME_LEN; k++) begin
            if (pos_r == POS_W'(k)) begin
              store_nxt[k] = up_char;
            end
          end
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= {NAME_LEN{PAD_CHAR}};
      pos_r   <= '0;
      dot_r   <= 1'b0;
      fail_r  <= 1'b0;
    end else begin
      store_r <= store_nxt;
      pos_r   <= pos_nxt;
      dot_r   <= dot_nxt;
      fail_r  <= fail_nxt;
    end
  end

endmodule

### hw/rtl/sn83_queue.sv
`timescale 1ns / 1ps
module sn83_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sn83_pkg::hs_t         push_hs,
  input  sn83_pkg::name_entry_t push_entry,
  output logic                  q_ready,
  output logic                  q_valid,
  output sn83_pkg::name_entry_t q_entry,
  input  logic                  pop
);
  import sn83_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(Q_DEPTH - 1);

  name_entry_t       entry_r [Q_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_ready = (count_r != CW'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = entry_r[rd_ptr_r];
  assign do_push = push_hs.valid && push_hs.ready && q_ready;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### hw/rtl/sn83_back.sv
`timescale 1ns / 1ps
module sn83_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  sn83_pkg::name_entry_t q_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_name_byte,
  output logic [3:0]            out_byte_index,
  output logic                  out_name_ok,
  output logic                  out_last
);
  import sn83_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NAME_LEN - 1);

  name_t            name_r, name_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ok_r, ok_nxt;
  logic             busy_r, busy_nxt;
  logic             fire;
  logic             at_last;

  assign at_last        = (idx_r == IDX_LAST);
  assign fire           = busy_r && out_ready;
  assign pop            = q_valid && (!busy_r || (fire && at_last));
  assign out_valid      = busy_r;
  assign out_name_byte  = name_r[0];
  assign out_byte_index = 4'(idx_r);
  assign out_name_ok    = ok_r;
  assign out_last       = at_last;

  always_comb begin
    name_nxt = name_r;
    idx_nxt  = idx_r;
    ok_nxt   = ok_r;
    busy_nxt = busy_r;
    if (pop) begin
      name_nxt = q_entry.bytes;
      ok_nxt   = q_entry.ok;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (fire) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        // shift the next byte down to the output slot
        for (int k = 0; k < NAME_LEN - 1; k++) begin
          name_nxt[k] = name_r[k+1];
        end
        name_nxt[NAME_LEN-1] = PAD_CHAR;
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    name_r <= name_nxt;
    ok_r   <= ok_nxt;
  end

endmodule
